[design/easf_pkg.sv]
package easf_pkg;

   // Pole pair register width and its value after reset.
   localparam int PP_BITS = 7;
   localparam logic [PP_BITS-1:0] PP_RESET = 7'd7;

   // Configuration channel geometry.
   localparam int CSR_INDEX_BITS = 8;
   localparam int CSR_DATA_BITS = 16;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_POLE_PAIRS  = 8'd0,
      CSR_ELEC_OFFSET = 8'd1
   } csr_index_type;

endpackage

[design/easf_if.sv]
interface easf_req_if #(
   parameter int ANGLE_BITS = 12
);
   logic                  valid;
   logic                  ready;
   logic [ANGLE_BITS-1:0] raw_angle;

   modport source (output valid, output raw_angle, input ready);
   modport sink (input valid, input raw_angle, output ready);
endinterface

interface easf_rsp_if #(
   parameter int ANGLE_BITS = 12,
   parameter int SUM_BITS = 17
);
   logic                       valid;
   logic                       ready;
   logic [ANGLE_BITS-1:0]      elec_angle;
   logic signed [ANGLE_BITS:0] step_delta;
   logic signed [SUM_BITS-1:0] speed_sum;

   modport source (output valid, output elec_angle, output step_delta, output speed_sum,
                   input ready);
   modport sink (input valid, input elec_angle, input step_delta, input speed_sum,
                 output ready);
endinterface

interface easf_csr_if
   import easf_pkg::*;
();
   logic                      valid;
   logic                      ready;
   logic [CSR_INDEX_BITS-1:0] index;
   logic [CSR_DATA_BITS-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

[design/easf_angle.sv]
module easf_angle
   import easf_pkg::*;
#(
   parameter int ANGLE_BITS = 12
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  logic [ANGLE_BITS-1:0] raw_angle,
   input  logic [PP_BITS-1:0]    pole_pairs,
   input  logic [ANGLE_BITS-1:0] elec_offset,
   input  logic                  out_ready,
   output logic                  in_ready,
   output logic                  out_valid,
   output logic [ANGLE_BITS-1:0] out_angle
);

   logic [ANGLE_BITS+PP_BITS-1:0] product;
   logic [ANGLE_BITS-1:0]         angle_in;
   logic [ANGLE_BITS-1:0]         angle_ff;
   logic                          valid_ff;
   logic                          valid_in;

   // One turn is a power of two, so keeping the low bits is the modulo.
   assign product  = {{PP_BITS{1'b0}}, raw_angle} * {{ANGLE_BITS{1'b0}}, pole_pairs};
   assign angle_in = product[ANGLE_BITS-1:0] - elec_offset;
   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (in_ready && in_valid) begin
         angle_ff <= angle_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_angle = angle_ff;

endmodule

[design/easf_cell.sv]
module easf_cell #(
   parameter int WIDTH = 13
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             shift,
   input  logic [WIDTH-1:0] d_in,
   output logic [WIDTH-1:0] d_out
);

   logic [WIDTH-1:0] d_ff;
   logic [WIDTH-1:0] d_next_in;

   assign d_next_in = shift ? d_in : d_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         d_ff <= '0;
      end else begin
         d_ff <= d_next_in;
      end
   end

   assign d_out = d_ff;

endmodule

[design/encoder_electrical_angle_speed_filter.sv]
// Channel  Dir  Handshake     Payload
// req      in   valid/ready   raw_angle
// rsp      out  valid/ready   elec_angle, step_delta, speed_sum
// csr      in   valid/ready   index, data (ready is always high)
//
// One transaction is taken every cycle unless a stall on rsp backs up to req; each one
// leaves on rsp after it is accepted and has passed the angle, delta and sum stages.
// Reset is synchronous and clears the pipeline, the previous angle, the running sum and
// every delta cell at once; the block takes transactions in the first cycle after reset.
// A stall on rsp backs up stage by stage, so empty stages keep filling until all three
// stages hold a transaction.
module encoder_electrical_angle_speed_filter
   import easf_pkg::*;
#(
   parameter int AVG_DEPTH = 16,
   parameter int ANGLE_BITS = 12
) (
   input logic        clock,
   input logic        reset,
   easf_req_if.sink   req,
   easf_rsp_if.source rsp,
   easf_csr_if.sink   csr
);

   localparam int DELTA_BITS = ANGLE_BITS + 1;
   localparam int SUM_BITS = ANGLE_BITS + $clog2(AVG_DEPTH) + 1;
   localparam logic signed [DELTA_BITS-1:0] HALF_TURN = DELTA_BITS'(2 ** (ANGLE_BITS - 1));
   // Adding a full turn in DELTA_BITS arithmetic is the same as subtracting one, so a
   // single constant serves for wrapping in either direction.
   localparam logic [DELTA_BITS-1:0] TURN_WRAP = {1'b1, {ANGLE_BITS{1'b0}}};

   // Configuration registers. Writes must be issued only while the block is idle; the block does not enforce it.
   logic [PP_BITS-1:0]    pole_pairs_ff;
   logic [ANGLE_BITS-1:0] elec_offset_ff;

   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pole_pairs_ff  <= PP_RESET;
         elec_offset_ff <= '0;
      end else if (csr.valid) begin
         if (csr.index == CSR_POLE_PAIRS) begin
            pole_pairs_ff <= csr.data[PP_BITS-1:0];
         end else if (csr.index == CSR_ELEC_OFFSET) begin
            elec_offset_ff <= csr.data[ANGLE_BITS-1:0];
         end
      end
   end

   // Stage handshake: each stage may load when it is empty or the next one moves.
   logic adv2;
   logic adv3;
   logic s1_valid;
   logic [ANGLE_BITS-1:0] s1_angle;

   // Stage 1: electrical angle from the encoder reading.
   easf_angle #(
      .ANGLE_BITS(ANGLE_BITS)
   ) u_angle (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req.valid),
      .raw_angle   (req.raw_angle),
      .pole_pairs  (pole_pairs_ff),
      .elec_offset (elec_offset_ff),
      .out_ready   (adv2),
      .in_ready    (req.ready),
      .out_valid   (s1_valid),
      .out_angle   (s1_angle)
   );

   // Stage 2: change against the previous angle, wrapped into half a turn either way.
   // A change of exactly half a turn is kept as it is.
   logic                         s2_valid_ff;
   logic                         s2_valid_in;
   logic [ANGLE_BITS-1:0]        s2_angle_ff;
   logic signed [DELTA_BITS-1:0] s2_delta_ff;
   logic signed [DELTA_BITS-1:0] s2_delta_in;
   logic signed [DELTA_BITS-1:0] diff;
   logic [ANGLE_BITS-1:0]        prev_angle_ff;
   logic                         load2;

   assign adv2        = !s2_valid_ff || adv3;
   assign load2       = adv2 && s1_valid;
   assign s2_valid_in = adv2 ? s1_valid : s2_valid_ff;
   assign diff        = $signed({1'b0, s1_angle}) - $signed({1'b0, prev_angle_ff});

   always_comb begin
      s2_delta_in = diff;
      if (diff > HALF_TURN || diff < -HALF_TURN) begin
         s2_delta_in = diff + $signed(TURN_WRAP);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff   <= 1'b0;
         prev_angle_ff <= '0;
      end else begin
         s2_valid_ff <= s2_valid_in;
         if (load2) begin
            prev_angle_ff <= s1_angle;
         end
      end
      if (load2) begin
         s2_angle_ff <= s1_angle;
         s2_delta_ff <= s2_delta_in;
      end
   end

   // Stage 3: the row of delta cells shifts once per transaction; the change that drops
   // off the far end is the one leaving the window, so the running sum takes it out and
   // the new change in.
   logic                         s3_valid_ff;
   logic                         s3_valid_in;
   logic [ANGLE_BITS-1:0]        s3_angle_ff;
   logic signed [DELTA_BITS-1:0] s3_delta_ff;
   logic signed [SUM_BITS-1:0]   sum_ff;
   logic signed [SUM_BITS-1:0]   sum_in;
   logic                         load3;
   logic [DELTA_BITS-1:0]        tap [AVG_DEPTH+1];
   logic signed [DELTA_BITS-1:0] oldest;

   assign adv3        = !s3_valid_ff || rsp.ready;
   assign load3       = adv3 && s2_valid_ff;
   assign s3_valid_in = adv3 ? s2_valid_ff : s3_valid_ff;
   assign tap[0]      = s2_delta_ff;
   assign oldest      = $signed(tap[AVG_DEPTH]);

   for (genvar i = 0; i < AVG_DEPTH; i++) begin : g_cell
      easf_cell #(
         .WIDTH(DELTA_BITS)
      ) u_cell (
         .clock (clock),
         .reset (reset),
         .shift (load3),
         .d_in  (tap[i]),
         .d_out (tap[i+1])
      );
   end

   assign sum_in = sum_ff - SUM_BITS'(oldest) + SUM_BITS'(s2_delta_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
         sum_ff      <= '0;
      end else begin
         s3_valid_ff <= s3_valid_in;
         if (load3) begin
            sum_ff <= sum_in;
         end
      end
      if (load3) begin
         s3_angle_ff <= s2_angle_ff;
         s3_delta_ff <= s2_delta_ff;
      end
   end

   assign rsp.valid      = s3_valid_ff;
   assign rsp.elec_angle = s3_angle_ff;
   assign rsp.step_delta = s3_delta_ff;
   assign rsp.speed_sum  = sum_ff;

endmodule
